// ===== src/sce_pkg.sv =====
// Shared types and constants for the stencil contrast enhancer.
`default_nettype none

package sce_pkg;

  localparam int SCE_MAX_WIDTH  = 2048;
  localparam int SCE_RST_WIDTH  = 640;
  localparam int SCE_RST_HEIGHT = 480;
  localparam int SCE_MAX_HEIGHT = 4096;

  localparam int MAP_AW = 14;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic             kind;
    logic [7:0]       pixel;
    logic [MAP_AW-1:0] table_addr;
    logic [7:0]       table_data;
  } sce_in_t;

  typedef struct packed {
    logic [7:0]       out_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;
  } sce_out_t;

  typedef struct packed {
    logic             vld;
    logic             flush;
    logic             first;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } sce_step_t;

  typedef struct packed {
    logic              vld;
    logic [MAP_AW-1:0] addr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } sce_look_t;

endpackage

`default_nettype wire

// ===== src/sce_line_buf.sv =====
// Two line memories: upper and middle line, read-modify-write per column.
`default_nettype none

module sce_line_buf #(
  parameter int DEPTH = sce_pkg::SCE_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]               wr_pix,
  output logic      [7:0]               up_q,
  output logic      [7:0]               mid_q
);
  logic [7:0] upper_mem [DEPTH];
  logic [7:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    up_q  <= upper_mem[rd_addr];
    mid_q <= middle_mem[rd_addr];
  end

  // shift the column down: middle moves to upper, new pixel to middle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_q;
      middle_mem[wr_addr] <= wr_pix;
    end
  end

endmodule

`default_nettype wire

// ===== src/sce_map.sv =====
// Enhancement map memory: one write port, one registered read port.
`default_nettype none

module sce_map (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [sce_pkg::MAP_AW-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic [sce_pkg::MAP_AW-1:0] raddr,
  output logic      [7:0]                q
);
  import sce_pkg::*;

  logic [7:0] map_mem [2**MAP_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    q <= map_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/sce_stencil.sv =====
// 3x3 window registers and map address computation.
`default_nettype none

module sce_stencil (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sce_pkg::sce_step_t step,
  input  wire logic [7:0]         col_top,
  input  wire logic [7:0]         col_mid,
  input  wire logic [7:0]         col_bot,
  output sce_pkg::sce_look_t      look_r
);
  import sce_pkg::*;

  logic [7:0] l_top_r, l_mid_r, l_bot_r;
  logic [7:0] m_top_r, m_mid_r, m_bot_r;

  logic [9:0]        corners;
  logic [9:0]        edges;
  logic [11:0]       gsum;
  logic signed [10:0] dsum;
  logic signed [10:0] dq;
  logic signed [7:0]  dofs;
  logic [5:0]        diff;
  logic [MAP_AW-1:0] addr;

  always_comb begin
    corners = 10'(l_top_r) + 10'(l_bot_r) + 10'(col_top) + 10'(col_bot);
    edges   = 10'(l_mid_r) + 10'(col_mid) + 10'(m_top_r) + 10'(m_bot_r);
    gsum    = 12'(corners) + 12'({edges, 1'b0}) + {2'b00, m_mid_r, 2'b00};
    dsum    = $signed({1'b0, m_mid_r, 2'b00}) - $signed({1'b0, corners});
    dq      = dsum >>> 4;
    dofs    = $signed(dq[7:0]) + 8'sd32;
    if (dofs < 8'sd0) begin
      diff = 6'd0;
    end else if (dofs > 8'sd63) begin
      diff = 6'd63;
    end else begin
      diff = dofs[5:0];
    end
    addr = {gsum[11:4], diff};
  end

  // advance window; clear left column at line start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_top_r <= '0;
      l_mid_r <= '0;
      l_bot_r <= '0;
      m_top_r <= '0;
      m_mid_r <= '0;
      m_bot_r <= '0;
    end else if (step.vld && !step.flush) begin
      if (step.first) begin
        l_top_r <= '0;
        l_mid_r <= '0;
        l_bot_r <= '0;
      end else begin
        l_top_r <= m_top_r;
        l_mid_r <= m_mid_r;
        l_bot_r <= m_bot_r;
      end
      m_top_r <= col_top;
      m_mid_r <= col_mid;
      m_bot_r <= col_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r.vld <= 1'b0;
    end else begin
      look_r.vld <= step.vld && step.emit;
    end
    look_r.addr <= addr;
    look_r.row  <= step.row;
    look_r.col  <= step.col;
    look_r.last <= step.last;
  end

endmodule

`default_nettype wire

// ===== src/sce_out_fifo.sv =====
// Output word queue decoupling the pipeline from result backpressure.
`default_nettype none

module sce_out_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire sce_pkg::sce_out_t           push_data,
  input  wire logic                        pop,
  output logic                             out_valid,
  output sce_pkg::sce_out_t                out_data,
  output logic      [sce_pkg::OFIFO_CW-1:0] count
);
  import sce_pkg::*;

  sce_out_t             fifo_mem [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OFIFO_CW-1:0]  cnt_r, cnt_nxt;
  logic                 do_pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign count     = cnt_r;
  assign do_pop    = pop && out_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/stencil_contrast_enhancer_top.sv =====
// Top level: 3x3 local contrast enhancer with line memories and map lookup.
// A result word passes stage 1, the stencil lookup register and stage 3 before it
// enters the output queue; the second result of a last column follows a flush step.
// Throughput: one word per cycle while the output queue has room; the last
// column of rows 2 and up holds input off during a flush step for its second result.
// Reset clears counters, window, pipeline valids and the output queue; line
// and map memories keep their contents and need no clearing pass.
`default_nettype none

module stencil_contrast_enhancer_top #(
  parameter int MAX_WIDTH = sce_pkg::SCE_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sce_pkg::sce_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sce_pkg::sce_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [sce_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [sce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sce_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WRST = (SCE_RST_WIDTH < MAX_WIDTH) ? SCE_RST_WIDTH : MAX_WIDTH;
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  logic [CW-1:0]    w_last_r, w_last_nxt;
  logic [ROW_W-1:0] h_last_r, h_last_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_vld_r, s1_flush_r;
  logic [7:0]       s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;

  logic             s3_vld_r;
  logic [ROW_W-1:0] s3_row_r;
  logic [COL_W-1:0] s3_col_r;
  logic             s3_last_r;

  logic              mw1_vld_r, mw2_vld_r;
  logic [MAP_AW-1:0] mw1_addr_r, mw2_addr_r;
  logic [7:0]        mw1_data_r, mw2_data_r;

  logic in_acc, pix_acc, map_we, cfg_hit;
  logic s1_first, s1_last, s1_deep, need_flush, room;

  logic [13:0]          lw;
  logic [12:0]          hv;
  logic [7:0]           up_q, mid_q, map_q;
  logic [7:0]           col_top, col_mid, col_bot;
  logic [OFIFO_CW-1:0]  fifo_cnt;
  sce_step_t            step;
  sce_look_t            look_r;
  sce_out_t             push_data;

  assign in_acc  = in_valid && in_ready;
  assign pix_acc = in_acc && (in_data.kind == KIND_PIXEL);
  assign map_we  = in_acc && (in_data.kind == KIND_TABLE);
  assign cfg_hit = cfg_we && ((cfg_addr == CFG_LINE_WIDTH) || (cfg_addr == CFG_FRAME_HEIGHT));

  assign s1_first   = (s1_col_r == '0);
  assign s1_last    = (s1_col_r == w_last_r);
  assign s1_deep    = (s1_row_r >= 12'd2);
  assign need_flush = s1_vld_r && !s1_flush_r && s1_last && s1_deep;

  assign room = (5'(fifo_cnt) + 5'(s1_vld_r) + 5'(look_r.vld) + 5'(s3_vld_r))
                <= 5'(OFIFO_DEPTH - 2);
  assign in_ready = !need_flush && room;

  // clamp configuration into last-column and last-row values
  always_comb begin
    lw         = {2'b00, cfg_data[11:0]};
    hv         = cfg_data[12:0];
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_we && (cfg_addr == CFG_LINE_WIDTH)) begin
      if (lw < 14'd3) begin
        w_last_nxt = CW'(2);
      end else if (lw > MAXW) begin
        w_last_nxt = CW'(MAX_WIDTH - 1);
      end else begin
        w_last_nxt = CW'(lw - 14'd1);
      end
    end
    if (cfg_we && (cfg_addr == CFG_FRAME_HEIGHT)) begin
      if (hv < 13'd3) begin
        h_last_nxt = 12'd2;
      end else if (hv > 13'(SCE_MAX_HEIGHT)) begin
        h_last_nxt = 12'(SCE_MAX_HEIGHT - 1);
      end else begin
        h_last_nxt = 12'(hv - 13'd1);
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (pix_acc) begin
      if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(WRST - 1);
      h_last_r <= 12'(SCE_RST_HEIGHT - 1);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // stage 1: line data arrives; insert a flush step after a last column of row 2 or later
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s1_flush_r <= 1'b0;
    end else if (need_flush) begin
      s1_vld_r   <= 1'b1;
      s1_flush_r <= 1'b1;
    end else begin
      s1_vld_r   <= pix_acc;
      s1_flush_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix_r <= in_data.pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // delay table writes through registers mw1 and mw2 so they stay in order with map lookups
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw1_vld_r <= 1'b0;
      mw2_vld_r <= 1'b0;
    end else begin
      mw1_vld_r <= map_we;
      mw2_vld_r <= mw1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mw1_addr_r <= in_data.table_addr;
    mw1_data_r <= in_data.table_data;
    mw2_addr_r <= mw1_addr_r;
    mw2_data_r <= mw1_data_r;
  end

  sce_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rd_addr(col_r),
    .wr_en  (s1_vld_r && !s1_flush_r),
    .wr_addr(s1_col_r),
    .wr_pix (s1_pix_r),
    .up_q   (up_q),
    .mid_q  (mid_q)
  );

  assign col_top = s1_flush_r ? 8'd0 : up_q;
  assign col_mid = s1_flush_r ? 8'd0 : mid_q;
  assign col_bot = s1_flush_r ? 8'd0 : s1_pix_r;

  always_comb begin
    step.vld   = s1_vld_r;
    step.flush = s1_flush_r;
    step.first = s1_first;
    step.emit  = s1_flush_r || (!s1_first && s1_deep);
    step.last  = s1_flush_r || !s1_last;
    step.row   = s1_row_r - 1'b1;
    step.col   = s1_flush_r ? COL_W'(s1_col_r) : COL_W'(s1_col_r - CW'(1));
  end

  sce_stencil u_stencil (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .col_top(col_top),
    .col_mid(col_mid),
    .col_bot(col_bot),
    .look_r (look_r)
  );

  sce_map u_map (
    .clk  (clk),
    .we   (mw2_vld_r),
    .waddr(mw2_addr_r),
    .wdata(mw2_data_r),
    .raddr(look_r.addr),
    .q    (map_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= look_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_row_r  <= look_r.row;
    s3_col_r  <= look_r.col;
    s3_last_r <= look_r.last;
  end

  always_comb begin
    push_data.out_pixel   = map_q;
    push_data.out_row     = s3_row_r;
    push_data.out_col     = s3_col_r;
    push_data.last_of_run = s3_last_r;
  end

  sce_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s3_vld_r),
    .push_data(push_data),
    .pop      (out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .count    (fifo_cnt)
  );

endmodule

`default_nettype wire

// ===== tb/stencil_contrast_enhancer_top_tb.sv =====
// Self-checking testbench for the 3x3 stencil contrast enhancer with map lookup.
module stencil_contrast_enhancer_top_tb;
  import sce_pkg::*;

  typedef struct packed {
    sce_in_t    wd;
    logic [1:0] n_res;
    sce_out_t   res0;
    sce_out_t   res1;
  } probe_t;

  localparam int MAP_SIZE = 1 << MAP_AW;
  localparam sce_out_t NO_RES = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sce_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sce_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = CFG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int src_idle_pct = 21;
  int dst_idle_pct = 80;
  int fail_count = 0;

  logic [11:0] width_reg = 12'(SCE_RST_WIDTH);
  logic [12:0] height_reg = 13'(SCE_RST_HEIGHT);
  int          col_pos = 0;
  int          row_pos = 0;
  logic [23:0] win_left = '0;
  logic [23:0] win_mid = '0;
  logic [7:0]  upper_mem [SCE_MAX_WIDTH];
  logic [7:0]  middle_mem [SCE_MAX_WIDTH];
  logic [7:0]  map_mem [MAP_SIZE];
  bit          map_set [MAP_SIZE];
  sce_out_t    expected_px [$];
  probe_t      probes [$];

  always #4 clk = ~clk;

  stencil_contrast_enhancer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // columns are packed {bottom, middle, top}
  function automatic int map_index(input logic [23:0] l, input logic [23:0] m,
                                   input logic [23:0] r);
    int corners, edges, c4, gauss, d, diff;
    corners = int'(l[7:0]) + int'(l[23:16]) + int'(r[7:0]) + int'(r[23:16]);
    edges = int'(l[15:8]) + int'(r[15:8]) + int'(m[7:0]) + int'(m[23:16]);
    c4 = 4 * int'(m[15:8]);
    gauss = (corners + 2 * edges + c4) >> 4;
    d = c4 - corners;
    diff = (d >>> 4) + 32;
    if (diff < 0) diff = 0;
    if (diff > 63) diff = 63;
    return gauss * 64 + diff;
  endfunction

  function automatic logic [7:0] lookup_contrast(input logic [23:0] l, input logic [23:0] m,
                                                 input logic [23:0] r);
    return map_mem[map_index(l, m, r)];
  endfunction

  function automatic sce_out_t res(input logic [7:0] px, input int row, input int col,
                                   input logic tail);
    sce_out_t o;
    o.out_pixel = px;
    o.out_row = ROW_W'(row);
    o.out_col = COL_W'(col);
    o.last_of_run = tail;
    return o;
  endfunction

  function automatic probe_t probe(input logic kind, input logic [7:0] px,
                                   input logic [MAP_AW-1:0] addr, input logic [7:0] data,
                                   input logic [1:0] n, input sce_out_t e0, input sce_out_t e1);
    probe_t p;
    p.wd.kind = kind;
    p.wd.pixel = px;
    p.wd.table_addr = addr;
    p.wd.table_data = data;
    p.n_res = n;
    p.res0 = e0;
    p.res1 = e1;
    return p;
  endfunction

  function automatic void stream_pos(output int w_eff, output int h_eff, output int c,
                                     output int r);
    w_eff = int'(width_reg);
    if (w_eff < 3) w_eff = 3;
    if (w_eff > SCE_MAX_WIDTH) w_eff = SCE_MAX_WIDTH;
    h_eff = int'(height_reg);
    if (h_eff < 3) h_eff = 3;
    if (h_eff > SCE_MAX_HEIGHT) h_eff = SCE_MAX_HEIGHT;
    c = col_pos;
    r = row_pos;
    if (c >= w_eff) c = 0;
    if (r >= h_eff) r = 0;
  endfunction

  // map entries the next word will look up
  function automatic void map_needs(input sce_in_t wd, output int n, output int a0,
                                    output int a1);
    int w_eff, h_eff, c, r;
    logic [23:0] cur;
    n = 0;
    a0 = 0;
    a1 = 0;
    if (wd.kind == KIND_PIXEL) begin
      stream_pos(w_eff, h_eff, c, r);
      if (c != 0 && r >= 2) begin
        cur = {wd.pixel, middle_mem[c], upper_mem[c]};
        a0 = map_index(win_left, win_mid, cur);
        n = 1;
        if (c == w_eff - 1) begin
          a1 = map_index(win_mid, cur, 24'h0);
          n = 2;
        end
      end
    end
  endfunction

  function automatic void advance_stream(input sce_in_t wd, output int n, output sce_out_t r0,
                                         output sce_out_t r1);
    int w_eff, h_eff, c, r;
    logic [23:0] cur;
    logic at_end;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (wd.kind == KIND_TABLE) begin
      map_mem[wd.table_addr] = wd.table_data;
      map_set[wd.table_addr] = 1'b1;
    end else begin
      stream_pos(w_eff, h_eff, c, r);
      cur = {wd.pixel, middle_mem[c], upper_mem[c]};
      if (c == 0) begin
        win_left = '0;
        win_mid = '0;
      end else if (r >= 2) begin
        at_end = (c == w_eff - 1);
        r0 = res(lookup_contrast(win_left, win_mid, cur), r - 1, c - 1, !at_end);
        n = 1;
        if (at_end) begin
          r1 = res(lookup_contrast(win_mid, cur, 24'h0), r - 1, c, 1'b1);
          n = 2;
        end
      end
      win_left = win_mid;
      win_mid = cur;
      upper_mem[c] = middle_mem[c];
      middle_mem[c] = wd.pixel;
      c++;
      if (c >= w_eff) begin
        c = 0;
        r++;
        if (r >= h_eff) r = 0;
      end
      col_pos = c;
      row_pos = r;
    end
  endfunction

  function automatic sce_in_t rand_word();
    sce_in_t wd;
    wd.kind = ($urandom_range(9) == 0) ? KIND_TABLE : KIND_PIXEL;
    case ($urandom_range(5))
      0: wd.pixel = 8'h00;
      1: wd.pixel = 8'hFF;
      default: wd.pixel = 8'($urandom_range(255));
    endcase
    wd.table_addr = MAP_AW'($urandom_range(MAP_SIZE - 1));
    wd.table_data = 8'($urandom_range(255));
    return wd;
  endfunction

  task automatic push_word(input sce_in_t wd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // write a map entry before its first lookup
  task automatic fill_entry(input int a);
    int n;
    sce_in_t wd;
    sce_out_t r0, r1;
    if (!map_set[a]) begin
      wd = '0;
      wd.kind = KIND_TABLE;
      wd.table_addr = MAP_AW'(a);
      wd.table_data = 8'($urandom_range(255));
      push_word(wd);
      advance_stream(wd, n, r0, r1);
    end
  endtask

  task automatic feed(input sce_in_t wd);
    int n, a0, a1;
    sce_out_t r0, r1;
    map_needs(wd, n, a0, a1);
    if (n > 0) fill_entry(a0);
    if (n > 1) fill_entry(a1);
    push_word(wd);
    advance_stream(wd, n, r0, r1);
    if (n > 0) expected_px.push_back(r0);
    if (n > 1) expected_px.push_back(r1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] hv,
                           input int count);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= CFG_LINE_WIDTH;
    cfg_data <= wv;
    @(posedge clk);
    cfg_addr <= CFG_FRAME_HEIGHT;
    cfg_data <= hv;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = wv[11:0];
    height_reg = hv;
    col_pos = 0;
    row_pos = 0;
    repeat (count) feed(rand_word());
  endtask

  always @(posedge clk) begin : result_side
    sce_out_t want;
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: unexpected word px=%0h row=%0d col=%0d last=%0b",
                   out_data.out_pixel, out_data.out_row, out_data.out_col,
                   out_data.last_of_run);
      end else begin
        want = expected_px.pop_front();
        if (out_data.out_pixel !== want.out_pixel || out_data.out_row !== want.out_row ||
            out_data.out_col !== want.out_col ||
            out_data.last_of_run !== want.last_of_run) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp px=%0h row=%0d col=%0d last=%0b, got px=%0h row=%0d col=%0d last=%0b",
                     want.out_pixel, want.out_row, want.out_col, want.last_of_run,
                     out_data.out_pixel, out_data.out_row, out_data.out_col,
                     out_data.last_of_run);
        end
      end
    end
  end

  initial begin
    int n;
    sce_out_t r0, r1;
    probe_t p;
    logic [7:0] board [6];

    probes.push_back(probe(KIND_TABLE, 8'hFF, 14'd12287, 8'h81, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_TABLE, 8'hFF, 14'd16352, 8'hC3, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_TABLE, 8'h00, 14'd4032, 8'h3C, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_TABLE, 8'h00, 14'd4064, 8'h7E, 2'd0, NO_RES, NO_RES));
    // flat white 3x3 frame: full-scale gauss in the centre, edge columns reach the top diff value
    repeat (7) probes.push_back(probe(KIND_PIXEL, 8'hFF, '0, '0, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_PIXEL, 8'hFF, '0, '0, 2'd1, res(8'h81, 1, 0, 1'b1), NO_RES));
    probes.push_back(probe(KIND_PIXEL, 8'hFF, '0, '0, 2'd2, res(8'hC3, 1, 1, 1'b0),
                           res(8'h81, 1, 2, 1'b1)));
    // bright corners on black: centre diff clamps low
    board = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
    foreach (board[i]) probes.push_back(probe(KIND_PIXEL, board[i], '0, '0, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_PIXEL, 8'hFF, '0, '0, 2'd0, NO_RES, NO_RES));
    probes.push_back(probe(KIND_PIXEL, 8'h00, '0, '0, 2'd1, res(8'h7E, 1, 0, 1'b1), NO_RES));
    probes.push_back(probe(KIND_PIXEL, 8'hFF, '0, '0, 2'd2, res(8'h3C, 1, 1, 1'b0),
                           res(8'h7E, 1, 2, 1'b1)));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(13'd3, 13'd3, 0);
    foreach (probes[i]) begin
      p = probes[i];
      push_word(p.wd);
      // advance the predictor; typed results stand in for its output here
      advance_stream(p.wd, n, r0, r1);
      if (p.n_res > 0) expected_px.push_back(p.res0);
      if (p.n_res > 1) expected_px.push_back(p.res1);
    end

    run_phase(13'd5, 13'd4, 36);
    run_phase(13'd0, 13'd8191, 30);
    run_phase(13'h1004, 13'd2, 36);

    src_idle_pct = 80;
    dst_idle_pct = 21;
    run_phase(13'd4095, 13'd3, 8);
    run_phase(13'd2048, 13'd1, 8);
    run_phase(13'd7, 13'd5, 48);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_phase(13'd1, 13'd0, 24);
    run_phase(13'd16, 13'd6, 60);
    run_phase(13'd9, 13'd3, 48);
    run_phase(13'd6, 13'd4096, 36);

    settle();
    if (fail_count == 0 && expected_px.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
